@@ rtl/wheel_tick_speed_odometer_core_macros.svh @@
// Assertion macros for the wheel tick speed odometer core.
// Included by the RTL files that carry assertions; expects clk and rst_n in scope.
`ifndef WHEEL_TICK_SPEED_ODOMETER_CORE_MACROS_SVH
`define WHEEL_TICK_SPEED_ODOMETER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Implication or plain property, checked out of reset
`define WTSO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen
`define WTSO_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define WTSO_ASSERT(lbl, prop, msg)
`define WTSO_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

@@ rtl/wtso_pkg.sv @@
// Shared types, constants and codes for the wheel tick speed odometer core.
// No dependencies; used by every module in rtl/.
package wtso_pkg;

    // Ring depth default
    localparam int TICK_DEPTH_DEF = 32;

    // Field widths
    localparam int CIRC_W  = 12;
    localparam int GAP_W   = 16;
    localparam int TIME_W  = 32;
    localparam int WIN_W   = 8;
    localparam int ADJ_W   = 21;
    localparam int SPEED_W = 16;
    localparam int DIST_W  = 32;

    // Config port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_CIRC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP  = 2'd1;
    localparam logic [GAP_W-1:0]     GAP_RESET = 16'd50;

    // Commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_SPEED = 2'd1;
    localparam logic [1:0] CMD_DIST  = 2'd2;
    localparam logic [1:0] CMD_ADJ   = 2'd3;

    // Datapath widths: working accumulator, multiplier operands, window limit, distance sum
    localparam int ACC_W   = 49;
    localparam int MUL_A_W = 44;
    localparam int MUL_B_W = 14;
    localparam int LIMIT_W = 18;
    localparam int DSUM_W  = 51;

    // Arithmetic constants
    localparam logic [LIMIT_W-1:0] WIN_MS      = 18'd1000;
    localparam logic [MUL_B_W-1:0] SPEED_SCALE = 14'd10000;
    localparam logic [MUL_B_W-1:0] ELAPSED_MUL = 14'd11;
    localparam logic [MUL_B_W-1:0] DIST_SCALE  = 14'd25;
    localparam logic [ACC_W-1:0]   DIST_DIV    = 49'd25344;

    localparam logic signed [DSUM_W-1:0] DSUM_MAX = 51'sd2147483647;
    localparam logic signed [DSUM_W-1:0] DSUM_MIN = -51'sd2147483648;
    localparam logic signed [DIST_W-1:0] I32_MAX  = 32'sh7FFFFFFF;
    localparam logic signed [DIST_W-1:0] I32_MIN  = 32'sh80000000;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK_RD,
        S_TICK_CHK,
        S_SPD_RD,
        S_WALK,
        S_SPD_MUL1,
        S_SPD_MUL2,
        S_SPD_MUL3,
        S_ADJ,
        S_DST_MUL1,
        S_DST_MUL2,
        S_DIV,
        S_DIV_WAIT,
        S_DST_SUM,
        S_DONE
    } state_t;

    // Ring commands and status
    typedef struct packed {
        logic wr;
        logic rd_newest;
        logic rd_older;
    } ring_cmd_t;

    typedef struct packed {
        logic empty;
        logic oldest;
    } ring_stat_t;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ rtl/wheel_tick_speed_odometer_core.sv @@
// Wheel tick speed odometer core: sequencer, shared multiplier and config registers.
// Speed queries examine stored ticks back from the newest, at most TICK_DEPTH of them.
// One request is handled at a time; the serial divider dominates the queries.
// Reset (rst_n, async low) clears counters, the ring fill and sets circumference 0, gap 50 ms.
// Depends on wtso_pkg, wtso_ring, wtso_divider and the macros header.
`include "wheel_tick_speed_odometer_core_macros.svh"

module wheel_tick_speed_odometer_core #(
    parameter int TICK_DEPTH = wtso_pkg::TICK_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wtso_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wtso_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Request channel
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [1:0]                          command,
    input  logic [wtso_pkg::TIME_W-1:0]         now_ms,
    input  logic [wtso_pkg::WIN_W-1:0]          window_seconds,
    input  logic signed [wtso_pkg::ADJ_W-1:0]   adjust_milli,
    // Result channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                tick_accepted,
    output logic [wtso_pkg::SPEED_W-1:0]        speed_q8,
    output logic signed [wtso_pkg::DIST_W-1:0]  distance_milli
);
    import wtso_pkg::*;

    localparam int CNT_W = $clog2(TICK_DEPTH + 1);

    // Control registers
    state_t                   state_reg, state_next;
    logic                     result_valid_reg, result_valid_next;
    logic [CIRC_W-1:0]        circ_reg, circ_next;
    logic [GAP_W-1:0]         gap_reg, gap_next;
    logic [TIME_W-1:0]        tick_total_reg, tick_total_next;
    logic signed [DIST_W-1:0] adjust_total_reg, adjust_total_next;

    // Working registers
    logic [1:0]               cmd_reg, cmd_next;
    logic [TIME_W-1:0]        now_reg, now_next;
    logic signed [ADJ_W-1:0]  adj_reg, adj_next;
    logic [LIMIT_W-1:0]       limit_reg, limit_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [TIME_W-1:0]        elapsed_reg, elapsed_next;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [ACC_W-1:0]         den_reg, den_next;
    logic                     res_acc_reg, res_acc_next;
    logic [SPEED_W-1:0]       res_speed_reg, res_speed_next;
    logic signed [DIST_W-1:0] res_dist_reg, res_dist_next;
    logic                     out_acc_reg, out_acc_next;
    logic [SPEED_W-1:0]       out_speed_reg, out_speed_next;
    logic signed [DIST_W-1:0] out_dist_reg, out_dist_next;

    // Shared multiplier
    logic [MUL_A_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic [MUL_A_W+MUL_B_W-1:0] mul_p;

    // Sub-unit hookup
    ring_cmd_t        ring_cmd;
    ring_stat_t       ring_stat;
    logic [TIME_W-1:0] ring_rdata;
    logic             div_start;
    logic [ACC_W-1:0] div_quot;
    div_stat_t        div_stat;

    // Helpers
    logic [TIME_W-1:0]        age;
    logic                     too_old;
    logic signed [DIST_W:0]   adj_sum;
    logic signed [DSUM_W-1:0] dist_sum;
    logic                     result_free;

    wtso_ring #(
        .TICK_DEPTH (TICK_DEPTH)
    ) u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ring_cmd),
        .wdata (now_reg),
        .rdata (ring_rdata),
        .stat  (ring_stat)
    );

    wtso_divider #(
        .DIV_W (ACC_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (den_reg),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    assign mul_p = mul_a * mul_b;

    // Age of the entry just read from the ring
    assign age     = now_reg - ring_rdata;
    assign too_old = age >= {{(TIME_W - LIMIT_W){1'b0}}, limit_reg};

    // Saturating adjustment accumulate and distance sum
    assign adj_sum  = {adjust_total_reg[DIST_W-1], adjust_total_reg}
                    + {{(DIST_W + 1 - ADJ_W){adj_reg[ADJ_W-1]}}, adj_reg};
    assign dist_sum = $signed({2'b00, acc_reg})
                    + {{(DSUM_W - DIST_W){adjust_total_reg[DIST_W-1]}}, adjust_total_reg};

    assign result_free = !result_valid_reg || !result_stall;

    assign cfg_ready  = 1'b1;
    assign item_stall = (state_reg != S_IDLE);

    // Sequencer: next state and datapath controls
    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = result_valid_reg;
        circ_next         = circ_reg;
        gap_next          = gap_reg;
        tick_total_next   = tick_total_reg;
        adjust_total_next = adjust_total_reg;
        cmd_next          = cmd_reg;
        now_next          = now_reg;
        adj_next          = adj_reg;
        limit_next        = limit_reg;
        n_next            = n_reg;
        elapsed_next      = elapsed_reg;
        acc_next          = acc_reg;
        den_next          = den_reg;
        res_acc_next      = res_acc_reg;
        res_speed_next    = res_speed_reg;
        res_dist_next     = res_dist_reg;
        out_acc_next      = out_acc_reg;
        out_speed_next    = out_speed_reg;
        out_dist_next     = out_dist_reg;
        mul_a             = '0;
        mul_b             = '0;
        ring_cmd          = '0;
        div_start         = 1'b0;

        // Result register drains independently of the sequencer
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        // Config writes
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CIRC: circ_next = cfg_data[CIRC_W-1:0];
                CFG_GAP:  gap_next  = cfg_data[GAP_W-1:0];
                default:  ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd_next       = command;
                    now_next       = now_ms;
                    adj_next       = adjust_milli;
                    limit_next     = LIMIT_W'(window_seconds) * WIN_MS;
                    res_acc_next   = 1'b0;
                    res_speed_next = '0;
                    res_dist_next  = '0;
                    case (command)
                        CMD_TICK:  state_next = S_TICK_RD;
                        CMD_SPEED: state_next = S_SPD_RD;
                        CMD_DIST:  state_next = S_DST_MUL1;
                        CMD_ADJ:   state_next = S_ADJ;
                        default:   state_next = S_DONE;
                    endcase
                end
            end

            // Tick: fetch newest stamp unless the ring is empty
            S_TICK_RD:
            begin
                if (ring_stat.empty)
                begin
                    ring_cmd.wr     = 1'b1;
                    tick_total_next = tick_total_reg + TIME_W'(1);
                    res_acc_next    = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    ring_cmd.rd_newest = 1'b1;
                    state_next         = S_TICK_CHK;
                end
            end

            S_TICK_CHK:
            begin
                if (age >= {{(TIME_W - GAP_W){1'b0}}, gap_reg})
                begin
                    ring_cmd.wr     = 1'b1;
                    tick_total_next = tick_total_reg + TIME_W'(1);
                    res_acc_next    = 1'b1;
                end
                state_next = S_DONE;
            end

            // Speed: walk back from the newest stamp
            S_SPD_RD:
            begin
                if (ring_stat.empty)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ring_cmd.rd_newest = 1'b1;
                    n_next             = '0;
                    state_next         = S_WALK;
                end
            end

            S_WALK:
            begin
                if (too_old || ring_stat.oldest)
                begin
                    elapsed_next = age;
                    n_next       = too_old ? n_reg : n_reg + CNT_W'(1);
                    state_next   = S_SPD_MUL1;
                end
                else
                begin
                    ring_cmd.rd_older = 1'b1;
                    n_next            = n_reg + CNT_W'(1);
                end
            end

            S_SPD_MUL1:
            begin
                mul_a      = MUL_A_W'(n_reg);
                mul_b      = MUL_B_W'(circ_reg);
                acc_next   = mul_p[ACC_W-1:0];
                state_next = S_SPD_MUL2;
            end

            S_SPD_MUL2:
            begin
                mul_a      = acc_reg[MUL_A_W-1:0];
                mul_b      = SPEED_SCALE;
                acc_next   = mul_p[ACC_W-1:0];
                state_next = S_SPD_MUL3;
            end

            S_SPD_MUL3:
            begin
                if (elapsed_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mul_a      = MUL_A_W'(elapsed_reg);
                    mul_b      = ELAPSED_MUL;
                    den_next   = mul_p[ACC_W-1:0];
                    state_next = S_DIV;
                end
            end

            // Adjustment, saturated to 32 bits signed
            S_ADJ:
            begin
                if (adj_sum[DIST_W] != adj_sum[DIST_W-1])
                begin
                    adjust_total_next = adj_sum[DIST_W] ? I32_MIN : I32_MAX;
                end
                else
                begin
                    adjust_total_next = adj_sum[DIST_W-1:0];
                end
                state_next = S_DST_MUL1;
            end

            // Distance: total * circ * 25 / 25344
            S_DST_MUL1:
            begin
                mul_a      = MUL_A_W'(tick_total_reg);
                mul_b      = MUL_B_W'(circ_reg);
                acc_next   = mul_p[ACC_W-1:0];
                state_next = S_DST_MUL2;
            end

            S_DST_MUL2:
            begin
                mul_a      = acc_reg[MUL_A_W-1:0];
                mul_b      = DIST_SCALE;
                acc_next   = mul_p[ACC_W-1:0];
                den_next   = DIST_DIV;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end

            S_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (cmd_reg == CMD_SPEED)
                    begin
                        res_speed_next = (|div_quot[ACC_W-1:SPEED_W]) ? '1
                                                                      : div_quot[SPEED_W-1:0];
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        acc_next   = div_quot;
                        state_next = S_DST_SUM;
                    end
                end
            end

            S_DST_SUM:
            begin
                if (dist_sum > DSUM_MAX)
                begin
                    res_dist_next = I32_MAX;
                end
                else if (dist_sum < DSUM_MIN)
                begin
                    res_dist_next = I32_MIN;
                end
                else
                begin
                    res_dist_next = dist_sum[DIST_W-1:0];
                end
                state_next = S_DONE;
            end

            // Hand over to the result register once it is free
            S_DONE:
            begin
                if (result_free)
                begin
                    out_acc_next      = res_acc_reg;
                    out_speed_next    = res_speed_reg;
                    out_dist_next     = res_dist_reg;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            circ_reg         <= '0;
            gap_reg          <= GAP_RESET;
            tick_total_reg   <= '0;
            adjust_total_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            circ_reg         <= circ_next;
            gap_reg          <= gap_next;
            tick_total_reg   <= tick_total_next;
            adjust_total_reg <= adjust_total_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        now_reg       <= now_next;
        adj_reg       <= adj_next;
        limit_reg     <= limit_next;
        n_reg         <= n_next;
        elapsed_reg   <= elapsed_next;
        acc_reg       <= acc_next;
        den_reg       <= den_next;
        res_acc_reg   <= res_acc_next;
        res_speed_reg <= res_speed_next;
        res_dist_reg  <= res_dist_next;
        out_acc_reg   <= out_acc_next;
        out_speed_reg <= out_speed_next;
        out_dist_reg  <= out_dist_next;
    end

    assign result_valid   = result_valid_reg;
    assign tick_accepted  = out_acc_reg;
    assign speed_q8       = out_speed_reg;
    assign distance_milli = out_dist_reg;

    // Checks
    `WTSO_ASSERT(a_div_idle_start, div_start |-> !div_stat.busy, "divider restarted while busy")
    `WTSO_ASSERT(a_tick_only, result_valid && tick_accepted |-> speed_q8 == '0 && distance_milli == '0, "tick result carries query data")
    `WTSO_ASSERT(a_wr_in_tick, ring_cmd.wr |-> state_reg == S_TICK_RD || state_reg == S_TICK_CHK, "ring write outside tick handling")
    `WTSO_ASSERT(a_fill_after_wr, ring_cmd.wr |=> !ring_stat.empty, "ring empty after a write")

endmodule

@@ rtl/wtso_ring.sv @@
// Timestamp ring: memory of accepted tick times with head pointer, fill count and walk pointer.
// Depends on wtso_pkg.
module wtso_ring #(
    parameter int TICK_DEPTH = wtso_pkg::TICK_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  wtso_pkg::ring_cmd_t       cmd,
    input  logic [wtso_pkg::TIME_W-1:0] wdata,
    output logic [wtso_pkg::TIME_W-1:0] rdata,
    output wtso_pkg::ring_stat_t      stat
);
    import wtso_pkg::*;

    localparam int PTR_W = (TICK_DEPTH > 1) ? $clog2(TICK_DEPTH) : 1;
    localparam int CNT_W = $clog2(TICK_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TICK_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TICK_DEPTH);

    logic [TIME_W-1:0] mem [TICK_DEPTH];
    logic [TIME_W-1:0] rd_data_reg;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] rd_k_reg, rd_k_next;

    logic [PTR_W-1:0] newest;
    logic [PTR_W-1:0] older;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;

    // Slot just behind the head, and the one behind the walk pointer
    assign newest = (head_reg == '0) ? PTR_LAST : head_reg - PTR_W'(1);
    assign older  = (rd_ptr_reg == '0) ? PTR_LAST : rd_ptr_reg - PTR_W'(1);
    assign rd_en  = cmd.rd_newest | cmd.rd_older;
    assign rd_addr = cmd.rd_newest ? newest : older;

    // Pointer and fill updates
    always_comb
    begin
        head_next   = head_reg;
        fill_next   = fill_reg;
        rd_ptr_next = rd_ptr_reg;
        rd_k_next   = rd_k_reg;
        if (cmd.wr)
        begin
            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);
            if (fill_reg != CNT_FULL)
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end
        if (cmd.rd_newest)
        begin
            rd_ptr_next = newest;
            rd_k_next   = '0;
        end
        else if (cmd.rd_older)
        begin
            rd_ptr_next = older;
            if (rd_k_reg != CNT_FULL)
            begin
                rd_k_next = rd_k_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            fill_reg   <= '0;
            rd_ptr_reg <= '0;
            rd_k_reg   <= '0;
        end
        else
        begin
            head_reg   <= head_next;
            fill_reg   <= fill_next;
            rd_ptr_reg <= rd_ptr_next;
            rd_k_reg   <= rd_k_next;
        end
    end

    // Storage: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[head_reg] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rdata       = rd_data_reg;
    assign stat.empty  = (fill_reg == '0);
    // Entry in rdata is the oldest stored one
    assign stat.oldest = ({1'b0, rd_k_reg} + (CNT_W + 1)'(1)) >= {1'b0, fill_reg};

endmodule

@@ rtl/wtso_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on wtso_pkg.
module wtso_divider #(
    parameter int DIV_W = wtso_pkg::ACC_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output wtso_pkg::div_stat_t stat
);
    import wtso_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;

    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             fits;

    // Trial subtract of the shifted remainder
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
